### rtl/rplm_pkg.sv
package rplm_pkg;

	// Sizes
	localparam int MAX_REFS_DEF = 16;
	localparam int BUF_W        = 5;
	localparam int FN_W         = 16;
	localparam int PN_W         = 17;
	localparam int LN_W         = 4;
	localparam int CFG_W        = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int LG_MIN       = 4;
	localparam int LG_MAX       = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOG2_MFN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_REFS = 2'd1;

	// Operations and slice kinds
	localparam logic       OP_MARK  = 1'b0;
	localparam logic       OP_BUILD = 1'b1;
	localparam logic [1:0] SK_I     = 2'd0;
	localparam logic [1:0] SK_P     = 2'd1;

	typedef enum logic [1:0] {
		MARK_UNUSED = 2'd0,
		MARK_SHORT  = 2'd1,
		MARK_LONG   = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_UNSUP   = 2'd2,
		ST_NOEVICT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_MSCAN,
		S_ROT,
		S_RESP,
		S_BCNT,
		S_BCHK,
		S_BSEL,
		S_BEMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    idr_commit;
		logic    sw_begin;
		logic    scan_dec;
		logic    drop;
		logic    rotate;
		logic    set_resp;
		status_t resp_status;
		logic    resp_zero_buf;
		logic    emit_resp;
		logic    cnt_begin;
		logic    cnt_step;
		logic    sel_begin;
		logic    sel_step;
		logic    emit_entry;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       op;
		logic       idr;
		logic       adaptive;
		logic [1:0] kind;
		logic       room;
		logic       idx_zero;
		logic       idx_short;
		logic       idx_at_n;
		logic       list_empty;
		logic       last_entry;
		logic       out_free;
	} sts_t;

endpackage

### rtl/ref_picture_list_manager_top.sv
// Reference picture store with sliding-window marking and P-slice list 0
// building. An IDR or adaptive mark item goes from dispatch straight to its
// response; a sliding-window mark, when the window is full, first searches
// downwards for a short-term slot and, if one is found, rotates it to the
// front before its response (with room, it rotates without a search). A build
// item for a P slice makes a counting pass and then finds each list entry by
// a one-slot-per-cycle scan of slots 1 to n of the store, n being the effective
// num_ref_frames. Other items give one result. One item is worked on at a time;
// a finished result sits in the output register while the next item is taken.
// Configuration writes are always ready and apply from the next cycle; indexes
// beyond the two registers are ignored.
module ref_picture_list_manager_top #(
	parameter int MAX_REFS = rplm_pkg::MAX_REFS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic                             is_idr,
	input  logic                             long_term_flag,
	input  logic                             adaptive_mode,
	input  logic [rplm_pkg::FN_W-1:0]        frame_num,
	input  logic [1:0]                       slice_kind,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rplm_pkg::BUF_W-1:0]       buffer_id,
	output logic signed [rplm_pkg::PN_W-1:0] pic_num,
	output logic                             is_long_term,
	output logic                             last,
	output logic [1:0]                       status,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rplm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rplm_pkg::CFG_W-1:0]       cfg_data
);
	import rplm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rplm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rplm_dp #(.MAX_REFS(MAX_REFS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.is_idr         (is_idr),
		.long_term_flag (long_term_flag),
		.adaptive_mode  (adaptive_mode),
		.frame_num      (frame_num),
		.slice_kind     (slice_kind),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.buffer_id      (buffer_id),
		.pic_num        (pic_num),
		.is_long_term   (is_long_term),
		.last           (last),
		.status         (status)
	);

endmodule

### rtl/rplm_ctrl.sv
module rplm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rplm_pkg::sts_t sts,
	output rplm_pkg::cmd_t cmd
);
	import rplm_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.op == OP_MARK) begin
					if (sts.idr || sts.adaptive) state_d = S_RESP;
					else if (sts.room)           state_d = S_ROT;
					else                         state_d = S_MSCAN;
				end else if (sts.kind == SK_P) begin
					state_d = S_BCNT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_MSCAN: begin
				if (sts.idx_zero)       state_d = S_RESP;
				else if (sts.idx_short) state_d = S_ROT;
			end
			S_ROT:  state_d = S_RESP;
			S_RESP: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_BCNT: begin
				if (sts.idx_at_n) state_d = S_BCHK;
			end
			S_BCHK: state_d = sts.list_empty ? S_RESP : S_BSEL;
			S_BSEL: begin
				if (sts.idx_at_n) state_d = S_BEMIT;
			end
			S_BEMIT: begin
				if (sts.out_free) state_d = sts.last_entry ? S_IDLE : S_BSEL;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load_in = in_valid;
			S_DISPATCH: begin
				cmd.set_resp = 1'b1;
				cmd.resp_status = ST_OK;
				if (sts.op == OP_MARK) begin
					if (sts.idr) begin
						cmd.idr_commit = 1'b1;
					end else if (sts.adaptive) begin
						cmd.resp_status = ST_UNSUP;
					end else begin
						cmd.sw_begin = 1'b1;
					end
				end else begin
					cmd.resp_zero_buf = 1'b1;
					if (sts.kind == SK_I)      cmd.resp_status = ST_EMPTY;
					else if (sts.kind != SK_P) cmd.resp_status = ST_UNSUP;
					else                       cmd.cnt_begin = 1'b1;
				end
			end
			S_MSCAN: begin
				if (sts.idx_zero) begin
					cmd.drop = 1'b1;
					cmd.set_resp = 1'b1;
					cmd.resp_status = ST_NOEVICT;
				end else if (!sts.idx_short) begin
					cmd.scan_dec = 1'b1;
				end
			end
			S_ROT:  cmd.rotate = 1'b1;
			S_RESP: cmd.emit_resp = sts.out_free;
			S_BCNT: cmd.cnt_step = 1'b1;
			S_BCHK: begin
				if (sts.list_empty) begin
					cmd.set_resp = 1'b1;
					cmd.resp_status = ST_EMPTY;
					cmd.resp_zero_buf = 1'b1;
				end else begin
					cmd.sel_begin = 1'b1;
				end
			end
			S_BSEL: cmd.sel_step = 1'b1;
			S_BEMIT: begin
				cmd.emit_entry = sts.out_free;
				cmd.sel_begin = sts.out_free && !sts.last_entry;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/rplm_dp.sv
module rplm_dp #(
	parameter int MAX_REFS = rplm_pkg::MAX_REFS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rplm_pkg::cmd_t                    cmd,
	output rplm_pkg::sts_t                    sts,
	input  logic                              cfg_we,
	input  logic [rplm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rplm_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              operation,
	input  logic                              is_idr,
	input  logic                              long_term_flag,
	input  logic                              adaptive_mode,
	input  logic [rplm_pkg::FN_W-1:0]         frame_num,
	input  logic [1:0]                        slice_kind,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [rplm_pkg::BUF_W-1:0]        buffer_id,
	output logic signed [rplm_pkg::PN_W-1:0]  pic_num,
	output logic                              is_long_term,
	output logic                              last,
	output logic [1:0]                        status
);
	import rplm_pkg::*;

	localparam int NSLOT = MAX_REFS + 1;
	localparam int SW    = $clog2(NSLOT);
	localparam int UW    = $clog2(NSLOT + 1);

	// Registers
	logic [CFG_W-1:0] lg_q, nref_q;
	logic [BUF_W-1:0] buf_q [NSLOT];
	mark_t            mark_q [NSLOT];
	logic [FN_W-1:0]  fn_q [NSLOT];
	logic [LN_W-1:0]  ln_q [NSLOT];
	logic [UW-1:0]    used_q;
	logic             op_q, idr_q, ltf_q, adp_q;
	logic [FN_W-1:0]  cur_q;
	logic [1:0]       kind_q;
	logic [SW-1:0]    idx_q;
	logic [NSLOT-1:0] emitted_q;
	logic [SW-1:0]    best_q;
	logic signed [PN_W-1:0] best_key_q;
	logic             found_q;
	logic [UW-1:0]    ns_q, nl_q, k_q;
	status_t          resp_st_q;
	logic             resp_zb_q;
	logic             out_valid_q;

	// Effective configuration
	logic [UW-1:0]   n_eff;
	logic [CFG_W-1:0] lg_eff;
	logic [PN_W-1:0] max_fn;
	always_comb begin
		if (nref_q == '0)                    n_eff = UW'(1);
		else if (nref_q > CFG_W'(MAX_REFS))  n_eff = UW'(MAX_REFS);
		else                                 n_eff = UW'(nref_q);
		if (lg_q < CFG_W'(LG_MIN))      lg_eff = CFG_W'(LG_MIN);
		else if (lg_q > CFG_W'(LG_MAX)) lg_eff = CFG_W'(LG_MAX);
		else                            lg_eff = lg_q;
		max_fn = PN_W'(1) << lg_eff;
	end

	// Key of the slot under the scan index
	logic                   want_long;
	logic [PN_W-1:0]        fn_ext;
	logic signed [PN_W-1:0] cand_key;
	logic                   cand, better;
	always_comb begin
		want_long = (k_q >= ns_q);
		fn_ext = {1'b0, fn_q[idx_q]};
		if (want_long)               cand_key = signed'(PN_W'(ln_q[idx_q]));
		else if (fn_q[idx_q] > cur_q) cand_key = signed'(fn_ext - max_fn);
		else                         cand_key = signed'(fn_ext);
		cand = !emitted_q[idx_q] &&
		       (mark_q[idx_q] == (want_long ? MARK_LONG : MARK_SHORT));
		better = !found_q || (want_long ? (cand_key <= best_key_q)
		                                : (cand_key >= best_key_q));
	end

	// Status
	logic [UW:0] total;
	assign total = {1'b0, ns_q} + {1'b0, nl_q};
	always_comb begin
		sts.op         = op_q;
		sts.idr        = idr_q;
		sts.adaptive   = adp_q;
		sts.kind       = kind_q;
		sts.room       = ({1'b0, used_q} < ({1'b0, n_eff} + (UW+1)'(1)));
		sts.idx_zero   = (idx_q == '0);
		sts.idx_short  = (mark_q[idx_q] == MARK_SHORT);
		sts.idx_at_n   = ((UW+1)'(idx_q) == {1'b0, n_eff});
		sts.list_empty = (total == '0);
		sts.last_entry = ({1'b0, k_q} + (UW+1)'(1) == total);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q   <= CFG_W'(LG_MIN);
			nref_q <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_LOG2_MFN) lg_q <= cfg_data;
			if (cfg_index == REG_NUM_REFS) nref_q <= cfg_data;
		end
	end

	// Latched input item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= operation;
			idr_q  <= is_idr;
			ltf_q  <= long_term_flag;
			adp_q  <= adaptive_mode;
			cur_q  <= frame_num;
			kind_q <= slice_kind;
		end
	end

	// Slot store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NSLOT; j++) begin
				buf_q[j]  <= BUF_W'(j);
				mark_q[j] <= MARK_UNUSED;
				fn_q[j]   <= '0;
				ln_q[j]   <= '0;
			end
			used_q <= UW'(1);
		end else if (cmd.idr_commit) begin
			for (int j = 2; j < NSLOT; j++) mark_q[j] <= MARK_UNUSED;
			buf_q[1]  <= buf_q[0];
			mark_q[1] <= ltf_q ? MARK_LONG : MARK_SHORT;
			fn_q[1]   <= cur_q;
			ln_q[1]   <= '0;
			buf_q[0]  <= buf_q[1];
			mark_q[0] <= MARK_UNUSED;
			fn_q[0]   <= fn_q[1];
			ln_q[0]   <= ln_q[1];
			used_q    <= UW'(2);
		end else if (cmd.sw_begin) begin
			mark_q[0] <= MARK_SHORT;
			fn_q[0]   <= cur_q;
			ln_q[0]   <= '0;
			if (sts.room) used_q <= used_q + UW'(1);
		end else if (cmd.drop) begin
			mark_q[0] <= MARK_UNUSED;
		end else if (cmd.rotate) begin
			// chosen slot to the front, the ones before it move up
			for (int j = 1; j < NSLOT; j++) begin
				if (SW'(j) <= idx_q) begin
					buf_q[j]  <= buf_q[j-1];
					mark_q[j] <= mark_q[j-1];
					fn_q[j]   <= fn_q[j-1];
					ln_q[j]   <= ln_q[j-1];
				end
			end
			buf_q[0]  <= buf_q[idx_q];
			mark_q[0] <= MARK_UNUSED;
			fn_q[0]   <= fn_q[idx_q];
			ln_q[0]   <= ln_q[idx_q];
		end
	end

	// Scan index, counts and selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			emitted_q  <= '0;
			best_q     <= '0;
			best_key_q <= '0;
			found_q    <= 1'b0;
			ns_q       <= '0;
			nl_q       <= '0;
			k_q        <= '0;
			resp_st_q  <= ST_OK;
			resp_zb_q  <= 1'b0;
		end else begin
			if (cmd.set_resp) begin
				resp_st_q <= cmd.resp_status;
				resp_zb_q <= cmd.resp_zero_buf;
			end
			if (cmd.sw_begin) idx_q <= sts.room ? SW'(used_q) : SW'(used_q - UW'(1));
			if (cmd.scan_dec) idx_q <= idx_q - SW'(1);
			if (cmd.cnt_begin) begin
				idx_q     <= SW'(1);
				ns_q      <= '0;
				nl_q      <= '0;
				k_q       <= '0;
				emitted_q <= '0;
			end
			if (cmd.cnt_step) begin
				if (mark_q[idx_q] == MARK_SHORT) ns_q <= ns_q + UW'(1);
				if (mark_q[idx_q] == MARK_LONG)  nl_q <= nl_q + UW'(1);
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.sel_begin) begin
				idx_q   <= SW'(1);
				found_q <= 1'b0;
			end
			if (cmd.sel_step) begin
				if (cand && better) begin
					best_q     <= idx_q;
					best_key_q <= cand_key;
					found_q    <= 1'b1;
				end
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.emit_entry) begin
				emitted_q[best_q] <= 1'b1;
				k_q <= k_q + UW'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                            out_valid_q <= 1'b0;
		else if (cmd.emit_resp || cmd.emit_entry) out_valid_q <= 1'b1;
		else if (!out_stall)                    out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_resp) begin
			buffer_id    <= resp_zb_q ? '0 : buf_q[0];
			pic_num      <= '0;
			is_long_term <= 1'b0;
			last         <= 1'b1;
			status       <= resp_st_q;
		end else if (cmd.emit_entry) begin
			buffer_id    <= buf_q[best_q];
			pic_num      <= best_key_q;
			is_long_term <= want_long;
			last         <= sts.last_entry;
			status       <= ST_OK;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/rplm_checker.sv
module rplm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [rplm_pkg::BUF_W-1:0]       buffer_id,
	input logic signed [rplm_pkg::PN_W-1:0] pic_num,
	input logic                             is_long_term,
	input logic                             last,
	input logic [1:0]                       status,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);
	import rplm_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(buffer_id) &&
		$stable(pic_num) && $stable(last) && $stable(status))
		else $error("stalled result changed");

	// One item at a time: an accepted item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not closed after accept");

	// Any non-ok status is a lone, final result
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last && !is_long_term && (pic_num == '0))
		else $error("status result malformed");

	// Long-term entries carry a four-bit number
	a_long_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_long_term |-> (status == ST_OK) && (pic_num[PN_W-1:LN_W] == '0))
		else $error("long-term entry out of range");

	// Configuration never waits
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind ref_picture_list_manager_top rplm_checker u_rplm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.buffer_id    (buffer_id),
	.pic_num      (pic_num),
	.is_long_term (is_long_term),
	.last         (last),
	.status       (status),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
